/* src/glcg_pkg.sv */
// Shared types and defaults for the grid line cell generator.
// Used by the stepper and the top level; no dependencies.
package glcg_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int MAX_CELLS_DEF  = 64;

    // Status of the line stepper toward the sequencer
    typedef struct packed {
        logic span_error;  // major span does not fit the buffer
        logic backward;    // walk ran goal to start, emit reversed
        logic at_end;      // current cell is the last one of the walk
    } t_step_status;

endpackage

/* src/grid_line_cell_generator_top.sv */
// Grid line cell generator top: stream ports, sequencer, output register.
// Depends on glcg_pkg, glcg_stepper and glcg_buffer.
//
// Takes one segment (start cell, goal cell) and returns the cells of an integer
// Bresenham line from start to goal, one request per cell, tlast on the final
// cell. A segment of major span M has M+1 cells. Starting the cycle after it is
// accepted, the stepper writes one cell a cycle to the cell buffer; then the
// buffer is read, one cell a cycle while the output is not stalled, and each
// read moves into the output register. The input is ready again once the last
// read has moved into the output register; a stalled output holds the sequencer
// cycle for cycle. Buffer read order is reversed when the walk ran from goal to
// start. A span above MAX_CELLS-1 returns a single request with tuser set and
// zero cells. The input side is ready only between segments.
module grid_line_cell_generator_top #(
    parameter int COORD_BITS = glcg_pkg::COORD_BITS_DEF,
    parameter int MAX_CELLS  = glcg_pkg::MAX_CELLS_DEF,
    parameter int IN_BITS    = ((4 * COORD_BITS + 7) / 8) * 8,
    parameter int OUT_BITS   = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // start_x, start_y, goal_x, goal_y from bit 0 up, zero padded
    input  logic [IN_BITS-1:0]  i_s_axis_tdata,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // cell_x, cell_y from bit 0 up, zero padded
    output logic [OUT_BITS-1:0] o_m_axis_tdata,
    output logic                o_m_axis_tlast,
    // span_error
    output logic                o_m_axis_tuser
);
    import glcg_pkg::*;

    localparam int ADDR_BITS = $clog2(MAX_CELLS);
    localparam int CNT_BITS  = $clog2(MAX_CELLS + 1);
    localparam int CELL_BITS = 2 * COORD_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_GEN  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;
    localparam logic [1:0] S_ERR  = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [CNT_BITS-1:0]   r_wr, r_issue, r_cnt;
    logic                  r_pend, r_pend_last;
    logic                  r_out_vld, r_out_last, r_out_err;
    logic [CELL_BITS-1:0]  r_out_cell;

    logic                  accept, gen_write, issue, move, out_free;
    logic [CNT_BITS-1:0]   rd_index;
    logic [COORD_BITS-1:0] cell_x, cell_y;
    logic [CELL_BITS-1:0]  rd_data;
    t_step_status          status;

    assign accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free  = !r_out_vld || i_m_axis_tready;
    assign gen_write = (r_state == S_GEN) && !status.span_error;
    assign move      = r_pend && out_free;
    assign issue     = (r_state == S_EMIT) && (r_issue != r_cnt) && (!r_pend || move);
    assign rd_index  = status.backward ? r_cnt - 1'b1 - r_issue : r_issue;

    glcg_stepper #(
        .COORD_BITS (COORD_BITS),
        .MAX_CELLS  (MAX_CELLS)
    ) u_stepper (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (accept),
        .i_step    (gen_write),
        .i_start_x (i_s_axis_tdata[COORD_BITS-1:0]),
        .i_start_y (i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_goal_x  (i_s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .i_goal_y  (i_s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .o_cell_x  (cell_x),
        .o_cell_y  (cell_y),
        .o_status  (status)
    );

    glcg_buffer #(
        .DEPTH (MAX_CELLS),
        .WIDTH (CELL_BITS)
    ) u_buffer (
        .i_clk   (i_clk),
        .i_we    (gen_write),
        .i_waddr (r_wr[ADDR_BITS-1:0]),
        .i_wdata ({cell_x, cell_y}),
        .i_re    (issue),
        .i_raddr (rd_index[ADDR_BITS-1:0]),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_GEN;
            end
            S_GEN: begin
                if (status.span_error) n_state = S_ERR;
                else if (status.at_end) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (move && r_pend_last) n_state = S_IDLE;
            end
            S_ERR: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wr      <= '0;
            r_issue   <= '0;
            r_cnt     <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_wr    <= '0;
                r_issue <= '0;
            end else if (gen_write) begin
                r_wr <= r_wr + 1'b1;
                // count latches as the final cell goes in
                if (status.at_end) r_cnt <= r_wr + 1'b1;
            end
            if (issue) begin
                r_issue <= r_issue + 1'b1;
                r_pend  <= 1'b1;
            end else if (move) begin
                r_pend <= 1'b0;
            end
            if (move || (r_state == S_ERR && out_free)) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pend_last <= (r_issue == r_cnt - 1'b1);
        end
        if (move) begin
            r_out_cell <= rd_data;
            r_out_last <= r_pend_last;
            r_out_err  <= 1'b0;
        end else if (r_state == S_ERR && out_free) begin
            r_out_cell <= '0;
            r_out_last <= 1'b1;
            r_out_err  <= 1'b1;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = OUT_BITS'({r_out_cell[COORD_BITS-1:0],
                                        r_out_cell[CELL_BITS-1:COORD_BITS]});
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_err;

endmodule

/* src/glcg_buffer.sv */
// Cell buffer: one write port, one read port with registered read data.
// Depends on nothing but its parameters.
module glcg_buffer #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 20
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/glcg_stepper.sv */
// Line stepper: orients a segment on load, then advances one cell per step
// through a shared error add / compare / subtract unit. Uses glcg_pkg.
module glcg_stepper #(
    parameter int COORD_BITS = glcg_pkg::COORD_BITS_DEF,
    parameter int MAX_CELLS  = glcg_pkg::MAX_CELLS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  logic                      i_step,
    input  logic [COORD_BITS-1:0]     i_start_x,
    input  logic [COORD_BITS-1:0]     i_start_y,
    input  logic [COORD_BITS-1:0]     i_goal_x,
    input  logic [COORD_BITS-1:0]     i_goal_y,
    output logic [COORD_BITS-1:0]     o_cell_x,
    output logic [COORD_BITS-1:0]     o_cell_y,
    output glcg_pkg::t_step_status    o_status
);
    import glcg_pkg::*;

    localparam int SPAN_BITS = (MAX_CELLS > 2) ? $clog2(MAX_CELLS) : 1;
    localparam int ERR_BITS  = SPAN_BITS + 1;
    localparam int WIDE      = COORD_BITS + SPAN_BITS;

    logic [COORD_BITS-1:0] r_pos, r_mpos;
    logic [SPAN_BITS-1:0]  r_left, r_major, r_minor;
    logic [ERR_BITS-1:0]   r_err;
    logic                  r_along, r_down, r_backward, r_span_err;

    logic [COORD_BITS-1:0] x1, y1, x2, y2, dx, dy, major_c, minor_c;
    logic [WIDE-1:0]       major_w, minor_w;
    logic [1:0]            mode;
    logic                  along, backward;
    logic [ERR_BITS-1:0]   err_sum, err_next;

    // orient the segment
    always_comb begin
        dx = (i_start_x > i_goal_x) ? i_start_x - i_goal_x : i_goal_x - i_start_x;
        dy = (i_start_y > i_goal_y) ? i_start_y - i_goal_y : i_goal_y - i_start_y;
        x1 = i_start_x;
        y1 = i_start_y;
        x2 = i_goal_x;
        y2 = i_goal_y;
        if (i_start_x > i_goal_x && i_start_y > i_goal_y) begin
            x1 = i_goal_x;
            x2 = i_start_x;
            y1 = i_goal_y;
            y2 = i_start_y;
            mode = 2'd0;
        end else if (i_goal_x >= i_start_x && i_goal_y >= i_start_y) begin
            mode = 2'd2;
        end else if (i_goal_y < i_start_y) begin
            y1 = i_goal_y;
            y2 = i_start_y;
            mode = 2'd1;
        end else begin
            x1 = i_goal_x;
            x2 = i_start_x;
            mode = 2'd3;
        end
        along    = dx >= dy;
        major_c  = along ? dx : dy;
        minor_c  = along ? dy : dx;
        major_w  = WIDE'(major_c);
        minor_w  = WIDE'(minor_c);
        backward = (mode == 2'd0) || (mode == 2'd1 && !along) || (mode == 2'd3 && along);
    end

    // shared error unit
    always_comb begin
        err_sum  = r_err + ERR_BITS'(r_minor);
        err_next = (err_sum >= ERR_BITS'(r_major)) ? err_sum - ERR_BITS'(r_major) : err_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err      <= '0;
            r_left     <= '0;
            r_span_err <= 1'b0;
        end else if (i_load) begin
            r_err      <= '0;
            r_left     <= major_w[SPAN_BITS-1:0];
            r_span_err <= major_w > WIDE'(MAX_CELLS - 1);
        end else if (i_step) begin
            r_err  <= err_next;
            r_left <= r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_along    <= along;
            r_major    <= major_w[SPAN_BITS-1:0];
            r_minor    <= minor_w[SPAN_BITS-1:0];
            r_backward <= backward;
            r_pos      <= along ? x1 : y1;
            r_down     <= mode[0];
            if (!mode[0]) begin
                r_mpos <= along ? y1 : x1;
            end else begin
                r_mpos <= along ? y2 : x2;
            end
        end else if (i_step) begin
            r_pos <= r_pos + 1'b1;
            if (err_sum >= ERR_BITS'(r_major)) begin
                r_mpos <= r_down ? r_mpos - 1'b1 : r_mpos + 1'b1;
            end
        end
    end

    assign o_cell_x            = r_along ? r_pos : r_mpos;
    assign o_cell_y            = r_along ? r_mpos : r_pos;
    assign o_status.span_error = r_span_err;
    assign o_status.backward   = r_backward;
    assign o_status.at_end     = (r_left == '0);

endmodule
